@@ hw/rtl/pool_refill_bin_policy_defines.svh @@
// Assertion macros shared by the pool refill policy RTL.
// Depends on nothing; users must provide signals named clk and rst_n.
`ifndef POOL_REFILL_BIN_POLICY_DEFINES_SVH
`define POOL_REFILL_BIN_POLICY_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PRBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prbp: assertion failed");

// Next-cycle implication, disabled while in reset.
`define PRBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prbp: assertion failed");

`endif

@@ hw/rtl/prbp_pkg.sv @@
// Types, constants and helper functions of the pool refill policy.
// Used by prbp_front, prbp_back and pool_refill_bin_policy.
`timescale 1ns / 1ps
`default_nettype none

package prbp_pkg;

  localparam int NUM_BINS     = 32;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_ALIGN    = 16;
  localparam int BIN_IDX_W    = $clog2(NUM_BINS);
  localparam int CNT_W        = 16;

  localparam logic [5:0]       RST_LOW_BLOCKED = 6'd8;
  localparam logic [5:0]       RST_HIGH_FROM   = 6'd32;
  localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_REFILL  = 2'd0,
    OP_RESERVE = 2'd1,
    OP_REWIND  = 2'd2,
    OP_RELEASE = 2'd3
  } prbp_op_t;

  typedef enum logic [1:0] {
    CFG_CONST_BYTES = 2'd0,
    CFG_LOW_BLOCKED = 2'd1,
    CFG_HIGH_FROM   = 2'd2
  } prbp_cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_CONST_REUSE = 3'd1,
    KIND_CONST_NEW   = 3'd2,
    KIND_BIN_REUSE   = 3'd3,
    KIND_BIN_NEW     = 3'd4,
    KIND_LARGE       = 3'd5,
    KIND_HOUSE       = 3'd6
  } prbp_kind_t;

  // Path an accepted transaction takes through the back end.
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_CONST = 2'd1,
    CLS_BIN   = 2'd2,
    CLS_HOUSE = 2'd3
  } prbp_cls_t;

  typedef struct packed {
    logic [31:0] const_block_bytes;
    logic [5:0]  low_blocked_bins;
    logic [5:0]  high_blocked_from;
  } prbp_cfg_t;

  typedef struct packed {
    prbp_cls_t           cls;
    logic                refill;
    logic                release_all;
    logic [31:0]         req;
    logic [NUM_BINS-1:0] below;
    logic [31:0]         aligned;
  } prbp_item_t;

  typedef struct packed {
    prbp_kind_t           kind;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [31:0]          buffer_bytes;
    logic [31:0]          fetch_bytes;
    logic [31:0]          freed_bin_mask;
    logic [CNT_W-1:0]     freed_const_blocks;
    logic [CNT_W-1:0]     freed_large_blocks;
  } prbp_res_t;

  function automatic logic [NUM_BINS-1:0] blocked_mask(input logic [5:0] lo,
                                                       input logic [5:0] hi);
    logic [NUM_BINS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      m[i] = (6'(i) < lo) || (6'(i) >= hi);
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  // Round up to the header alignment, saturating at the 32-bit maximum.
  function automatic logic [31:0] header_aligned(input logic [31:0] bytes);
    logic [32:0] s;
    s = ({1'b0, bytes} + 33'(HEADER_BYTES - 1)) & ~33'(MAX_ALIGN - 1);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pool_refill_bin_policy.sv @@
// Pool refill policy: an item is written into a two-entry queue on acceptance
// and its result shows on the output ports once the back end registers it.
// Throughput is one item per cycle, set by the combinational bin search and
// count update in the back end; a full result register stalls the queue.
// Reset (synchronous, rst_n low) empties the queue and the result register,
// clears the block counts and fetched mask, and restores the configuration
// registers and in-use mask.
`timescale 1ns / 1ps
`default_nettype none

module pool_refill_bin_policy (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_request_bytes,
  input  wire logic        in_buffer_fits,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_kind,
  output logic [4:0]       out_bin_index,
  output logic [31:0]      out_buffer_bytes,
  output logic [31:0]      out_fetch_bytes,
  output logic [31:0]      out_freed_bin_mask,
  output logic [15:0]      out_freed_const_blocks,
  output logic [15:0]      out_freed_large_blocks,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import prbp_pkg::*;

  prbp_cfg_t  cfg_r;
  prbp_item_t item;
  logic       item_valid;
  logic       take;
  logic       res_valid;
  prbp_res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.const_block_bytes <= '0;
      cfg_r.low_blocked_bins  <= RST_LOW_BLOCKED;
      cfg_r.high_blocked_from <= RST_HIGH_FROM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (prbp_cfg_idx_t'(cfg_index))
        CFG_CONST_BYTES: cfg_r.const_block_bytes <= cfg_data;
        CFG_LOW_BLOCKED: cfg_r.low_blocked_bins  <= cfg_data[5:0];
        CFG_HIGH_FROM:   cfg_r.high_blocked_from <= cfg_data[5:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  prbp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .const_block_bytes (cfg_r.const_block_bytes),
    .push              (in_push),
    .full              (in_full),
    .op                (in_op),
    .request_bytes     (in_request_bytes),
    .buffer_fits       (in_buffer_fits),
    .item_valid        (item_valid),
    .item              (item),
    .take              (take)
  );

  prbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .pop        (out_pop)
  );

  assign out_empty              = !res_valid;
  assign out_kind               = res.kind;
  assign out_bin_index          = res.bin_index;
  assign out_buffer_bytes       = res.buffer_bytes;
  assign out_fetch_bytes        = res.fetch_bytes;
  assign out_freed_bin_mask     = res.freed_bin_mask;
  assign out_freed_const_blocks = res.freed_const_blocks;
  assign out_freed_large_blocks = res.freed_large_blocks;

endmodule

`default_nettype wire

@@ hw/rtl/prbp_front.sv @@
// Front end: accepts transactions, classifies them and holds them in a
// two-entry queue for the back end. Depends on prbp_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "pool_refill_bin_policy_defines.svh"

module prbp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [31:0]         const_block_bytes,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          op,
  input  wire logic [31:0]         request_bytes,
  input  wire logic                buffer_fits,
  output logic                     item_valid,
  output prbp_pkg::prbp_item_t     item,
  input  wire logic                take
);
  import prbp_pkg::*;

  prbp_item_t  q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push_ok;
  prbp_item_t  cls_item;
  logic [31:0] req_m1;
  prbp_op_t    op_e;

  assign op_e    = prbp_op_t'(op);
  assign full    = (cnt_r == 2'd2);
  assign push_ok = push && !full;
  assign req_m1  = request_bytes - 32'd1;

  always_comb begin
    cls_item.refill      = (op_e == OP_REFILL);
    cls_item.release_all = (op_e == OP_RELEASE);
    cls_item.req         = request_bytes;
    // Bin i lies below the request when 2^i < request, i.e. request-1 has a
    // set bit at or above i.
    for (int i = 0; i < NUM_BINS; i++) begin
      cls_item.below[i] = |(req_m1 >> i);
    end
    if (op_e == OP_REWIND || op_e == OP_RELEASE) begin
      cls_item.cls = CLS_HOUSE;
    end else if (request_bytes == 32'd0 || (op_e == OP_RESERVE && buffer_fits)) begin
      cls_item.cls = CLS_NONE;
    end else if (request_bytes <= const_block_bytes) begin
      cls_item.cls = CLS_CONST;
    end else begin
      cls_item.cls = CLS_BIN;
    end
    cls_item.aligned = header_aligned((cls_item.cls == CLS_CONST) ? const_block_bytes
                                                                   : request_bytes);
  end

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls_item;
    end
  end

  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  `PRBP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 2'd2)
  `PRBP_ASSERT_IMP(a_no_take_empty, take, cnt_r != 2'd0)
  `PRBP_ASSERT_NXT(a_push_counts, push_ok && !take, cnt_r == $past(cnt_r) + 2'd1)

endmodule

`default_nettype wire

@@ hw/rtl/prbp_back.sv @@
// Back end: holds the bin masks and block counts, carries out the queued
// transaction and registers its result. Depends on prbp_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "pool_refill_bin_policy_defines.svh"

module prbp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire prbp_pkg::prbp_cfg_t   cfg,
  input  wire logic                  item_valid,
  input  wire prbp_pkg::prbp_item_t  item,
  output logic                       take,
  output logic                       res_valid,
  output prbp_pkg::prbp_res_t        res,
  input  wire logic                  pop
);
  import prbp_pkg::*;

  logic [NUM_BINS-1:0]  in_use_r, in_use_nxt;
  logic [NUM_BINS-1:0]  fetched_r, fetched_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     large_r, large_nxt;
  logic                 valid_r, valid_nxt;
  prbp_res_t            res_r, res_nxt;

  logic [NUM_BINS-1:0]  blocked;
  logic [NUM_BINS-1:0]  avail;
  logic [NUM_BINS-1:0]  ready;
  logic [NUM_BINS-1:0]  pick;
  logic [NUM_BINS-1:0]  bit_sel;
  logic [BIN_IDX_W-1:0] idx;

  assign blocked = blocked_mask(cfg.low_blocked_bins, cfg.high_blocked_from);
  assign avail   = ~(in_use_r | blocked | item.below);
  assign ready   = fetched_r & avail;
  assign pick    = (|ready) ? ready : avail;

  always_comb begin
    idx = '0;
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (pick[i]) begin
        idx = BIN_IDX_W'(i);
      end
    end
  end

  assign bit_sel = NUM_BINS'(1) << idx;

  // The result slot frees up in the cycle it is popped.
  assign take = item_valid && (!valid_r || pop);

  always_comb begin
    in_use_nxt  = in_use_r;
    fetched_nxt = fetched_r;
    total_nxt   = total_r;
    used_nxt    = used_r;
    large_nxt   = large_r;
    res_nxt     = '0;
    res_nxt.kind = KIND_NONE;
    case (item.cls)
      CLS_HOUSE: begin
        res_nxt.kind               = KIND_HOUSE;
        res_nxt.freed_large_blocks = large_r;
        large_nxt                  = '0;
        used_nxt                   = '0;
        in_use_nxt                 = blocked;
        if (item.release_all) begin
          res_nxt.freed_bin_mask     = fetched_r;
          res_nxt.freed_const_blocks = total_r;
          fetched_nxt                = '0;
          total_nxt                  = '0;
        end
      end
      CLS_CONST: begin
        if (used_r < total_r) begin
          res_nxt.kind = KIND_CONST_REUSE;
        end else begin
          res_nxt.kind        = KIND_CONST_NEW;
          res_nxt.fetch_bytes = item.aligned;
          total_nxt           = inc_sat(total_r);
        end
        if (item.refill) begin
          used_nxt             = inc_sat(used_r);
          res_nxt.buffer_bytes = cfg.const_block_bytes;
        end
      end
      CLS_BIN: begin
        if (|pick) begin
          res_nxt.bin_index = idx;
          if (fetched_r[idx]) begin
            res_nxt.kind = KIND_BIN_REUSE;
          end else begin
            res_nxt.kind        = KIND_BIN_NEW;
            res_nxt.fetch_bytes = 32'(bit_sel);
            fetched_nxt         = fetched_r | bit_sel;
          end
          if (item.refill) begin
            res_nxt.buffer_bytes = 32'(bit_sel);
            in_use_nxt           = in_use_r | bit_sel;
          end
        end else begin
          res_nxt.kind         = KIND_LARGE;
          res_nxt.fetch_bytes  = item.aligned;
          res_nxt.buffer_bytes = item.req;
          large_nxt            = inc_sat(large_r);
        end
      end
      default: begin
        res_nxt.kind = KIND_NONE;
      end
    endcase
    valid_nxt = take ? 1'b1 : (pop ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= blocked_mask(RST_LOW_BLOCKED, RST_HIGH_FROM);
      fetched_r <= '0;
      total_r   <= '0;
      used_r    <= '0;
      large_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        in_use_r  <= in_use_nxt;
        fetched_r <= fetched_nxt;
        total_r   <= total_nxt;
        used_r    <= used_nxt;
        large_r   <= large_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

  `PRBP_ASSERT_IMP(a_used_le_total, 1'b1, used_r <= total_r)
  `PRBP_ASSERT_NXT(a_house_clears_large, take && item.cls == CLS_HOUSE, large_r == '0)
  `PRBP_ASSERT_NXT(a_none_kind, take && item.cls == CLS_NONE,
                   valid_r && res_r.kind == KIND_NONE)

endmodule

`default_nettype wire
